// ----- design/rv32_pkg.sv -----
`default_nettype none

package rv32_pkg;

    localparam int XLEN      = 32;
    localparam int NUM_REGS  = 32;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int DIV_STEPS = XLEN;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    localparam logic [6:0] OP_RTYPE  = 7'h33;
    localparam logic [6:0] OP_ITYPE  = 7'h13;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    typedef struct packed {
        logic load;       // latch instruction word, read register file
        logic div_start;  // load divider operands
        logic div_step;   // one quotient bit
        logic commit;     // update state, load result word
    } rv32_cmd_t;

    typedef struct packed {
        logic is_div;
        logic div_done;
    } rv32_sts_t;

endpackage

`default_nettype wire

// ----- design/rv32im_integer_execute_core.sv -----
// RV32IM execute core: one instruction word in, one result word out (new PC, register
// write, status). Supported: RV32I ALU ops except sltu/sltiu (register and immediate), beq, bne, jal, lui,
// auipc, and mul, mulh, div, rem; anything else reports status 1 and changes no state.
// An instruction passes from acceptance to commit through accepting and reading registers,
// decoding with the multiply register, and commit; div and rem add the one-bit-per-cycle
// divider (32 steps and a done check) between decode and commit. A new word is taken
// once the previous one has committed, while its result may still wait on m_ready.
`default_nettype none

module rv32im_integer_execute_core
    import rv32_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [XLEN-1:0]   s_instruction_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [XLEN-1:0]        m_next_pc,
    output logic [REG_AW-1:0]      m_dest_index,
    output logic [XLEN-1:0]        m_write_value,
    output logic                   m_reg_written,
    output logic                   m_status
);

    rv32_cmd_t cmd;
    rv32_sts_t sts;

    rv32_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rv32_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_instruction_word (s_instruction_word),
        .cmd                (cmd),
        .sts                (sts),
        .m_next_pc          (m_next_pc),
        .m_dest_index       (m_dest_index),
        .m_write_value      (m_write_value),
        .m_reg_written      (m_reg_written),
        .m_status           (m_status)
    );

endmodule

`default_nettype wire

// ----- design/rv32_ctrl.sv -----
`default_nettype none

module rv32_ctrl
    import rv32_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire rv32_sts_t sts,
    output rv32_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_WB
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_WB;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_WB: begin
                // result word register must be free
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/rv32_dp.sv -----
`default_nettype none

module rv32_dp
    import rv32_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [XLEN-1:0]  s_instruction_word,
    input  wire rv32_cmd_t        cmd,
    output rv32_sts_t             sts,
    output logic [XLEN-1:0]       m_next_pc,
    output logic [REG_AW-1:0]     m_dest_index,
    output logic [XLEN-1:0]       m_write_value,
    output logic                  m_reg_written,
    output logic                  m_status
);

    logic [XLEN-1:0]   regs [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [XLEN-1:0]   pc_reg;
    logic [XLEN-1:0]   instr_reg;
    logic [XLEN-1:0]   a_q_reg, b_q_reg;
    logic              a_v_reg, b_v_reg;
    logic signed [2*XLEN-1:0] prod_reg;

    logic [XLEN-1:0]   dvsr_reg, rem_reg, quo_reg;
    logic [DIV_CW-1:0] cnt_reg;

    logic [XLEN-1:0]   npc_reg, val_reg;
    logic [REG_AW-1:0] rd_out_reg;
    logic              wr_out_reg, st_out_reg;

    logic [XLEN-1:0]   a, b, opnd, imm_i, off_b, off_j, alu, val, npc, pc4;
    logic [XLEN-1:0]   quo_fix, rem_fix, mag_a, mag_b;
    logic [6:0]        op, f7;
    logic [2:0]        f3;
    logic [REG_AW-1:0] rd;
    logic [4:0]        sh;
    logic              ok, writes, alt, is_r, is_div, do_wr;
    logic [XLEN:0]     dsh, ddiff;

    assign op    = instr_reg[6:0];
    assign rd    = instr_reg[11:7];
    assign f3    = instr_reg[14:12];
    assign f7    = instr_reg[31:25];
    assign a     = a_v_reg ? a_q_reg : '0;
    assign b     = b_v_reg ? b_q_reg : '0;
    assign imm_i = {{20{instr_reg[31]}}, instr_reg[31:20]};
    assign off_b = {{19{instr_reg[31]}}, instr_reg[31], instr_reg[7],
                    instr_reg[30:25], instr_reg[11:8], 1'b0};
    assign off_j = {{11{instr_reg[31]}}, instr_reg[31], instr_reg[19:12],
                    instr_reg[20], instr_reg[30:21], 1'b0};
    assign is_r  = (op == OP_RTYPE);
    assign alt   = (f7 == F7_ALT);
    assign opnd  = is_r ? b : imm_i;
    assign sh    = opnd[4:0];
    assign pc4   = pc_reg + 32'd4;
    assign mag_a = a[XLEN-1] ? (~a + 1'b1) : a;
    assign mag_b = b[XLEN-1] ? (~b + 1'b1) : b;

    assign is_div = is_r && (f7 == F7_MULDIV) && (f3 == F3_DIV || f3 == F3_REM);
    assign sts.is_div   = is_div;
    assign sts.div_done = (cnt_reg == DIV_CW'(DIV_STEPS));

    // spec results for divide by zero; overflow falls out of the magnitudes
    assign quo_fix = (b == '0) ? '1 : ((a[XLEN-1] ^ b[XLEN-1]) ? (~quo_reg + 1'b1) : quo_reg);
    assign rem_fix = (b == '0) ? a : (a[XLEN-1] ? (~rem_reg + 1'b1) : rem_reg);

    always_comb begin
        case (f3)
            F3_ADD:  alu = (is_r && alt) ? (a - opnd) : (a + opnd);
            F3_SLL:  alu = a << sh;
            F3_SLT:  alu = {31'd0, ($signed(a) < $signed(opnd))};
            F3_XOR:  alu = a ^ opnd;
            F3_SRL:  alu = alt ? XLEN'($signed(a) >>> sh) : (a >> sh);
            F3_OR:   alu = a | opnd;
            F3_AND:  alu = a & opnd;
            default: alu = '0;
        endcase
    end

    always_comb begin
        ok     = 1'b1;
        writes = 1'b1;
        val    = alu;
        npc    = pc4;
        unique case (op)
            OP_RTYPE: begin
                if (f7 == F7_BASE) begin
                    ok = (f3 != F3_SLTU);
                end else if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_MUL:  val = prod_reg[XLEN-1:0];
                        F3_MULH: val = prod_reg[2*XLEN-1:XLEN];
                        F3_DIV:  val = quo_fix;
                        F3_REM:  val = rem_fix;
                        default: ok = 1'b0;
                    endcase
                end else if (alt) begin
                    ok = (f3 == F3_ADD) || (f3 == F3_SRL);
                end else begin
                    ok = 1'b0;
                end
            end
            OP_ITYPE: begin
                case (f3)
                    F3_SLL:  ok = (f7 == F7_BASE);
                    F3_SRL:  ok = (f7 == F7_BASE) || alt;
                    F3_SLTU: ok = 1'b0;
                    default: ok = 1'b1;
                endcase
            end
            OP_BRANCH: begin
                writes = 1'b0;
                if (f3 == F3_BEQ) begin
                    if (a == b) npc = pc_reg + off_b;
                end else if (f3 == F3_BNE) begin
                    if (a != b) npc = pc_reg + off_b;
                end else begin
                    ok = 1'b0;
                end
            end
            OP_JAL: begin
                val = pc4;
                npc = pc_reg + off_j;
            end
            OP_LUI:   val = {instr_reg[31:12], 12'd0};
            OP_AUIPC: val = pc_reg + {instr_reg[31:12], 12'd0};
            default:  ok = 1'b0;
        endcase
    end

    assign do_wr = ok && writes && (rd != '0);
    assign dsh   = {rem_reg, quo_reg[XLEN-1]};
    assign ddiff = dsh - {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            pc_reg  <= '0;
        end else if (cmd.commit) begin
            if (do_wr) vld_reg[rd] <= 1'b1;
            if (ok) pc_reg <= npc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && do_wr) begin
            regs[rd] <= val;
        end
        if (cmd.load) begin
            instr_reg <= s_instruction_word;
            a_q_reg   <= regs[s_instruction_word[19:15]];
            b_q_reg   <= regs[s_instruction_word[24:20]];
            a_v_reg   <= vld_reg[s_instruction_word[19:15]];
            b_v_reg   <= vld_reg[s_instruction_word[24:20]];
        end
        prod_reg <= $signed(a) * $signed(b);
        if (cmd.div_start) begin
            dvsr_reg <= mag_b;
            rem_reg  <= '0;
            quo_reg  <= mag_a;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            if (!ddiff[XLEN]) begin
                rem_reg <= ddiff[XLEN-1:0];
                quo_reg <= {quo_reg[XLEN-2:0], 1'b1};
            end else begin
                rem_reg <= dsh[XLEN-1:0];
                quo_reg <= {quo_reg[XLEN-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.commit) begin
            npc_reg    <= ok ? npc : pc_reg;
            rd_out_reg <= do_wr ? rd : '0;
            val_reg    <= do_wr ? val : '0;
            wr_out_reg <= do_wr;
            st_out_reg <= !ok;
        end
    end

    assign m_next_pc     = npc_reg;
    assign m_dest_index  = rd_out_reg;
    assign m_write_value = val_reg;
    assign m_reg_written = wr_out_reg;
    assign m_status      = st_out_reg;

endmodule

`default_nettype wire

// ----- verif/rv32im_integer_execute_core_tb.sv -----
`default_nettype none

module rv32im_integer_execute_core_tb;
    import rv32_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 1550;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  dest_index;
        logic [31:0] write_value;
        logic        reg_written;
        logic        status;
    } exec_result_t;

    typedef struct {
        logic [31:0] word;
        logic        has_fixed;
        exec_result_t fixed;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_instruction_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_pc;
    logic [4:0]  m_dest_index;
    logic [31:0] m_write_value;
    logic        m_reg_written;
    logic        m_status;

    logic [31:0]  gpr_model [32];
    logic [31:0]  pc_model;
    exec_result_t result_queue [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           words_sent = 0;
    int           words_checked = 0;
    int           sender_gap_pct = 0;
    int           receiver_gap_pct = 0;

    rv32im_integer_execute_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_instruction_word(s_instruction_word),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_next_pc(m_next_pc), .m_dest_index(m_dest_index),
        .m_write_value(m_write_value), .m_reg_written(m_reg_written),
        .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] sra_word(logic [31:0] v, logic [4:0] sh);
        return $unsigned($signed(v) >>> sh);
    endfunction

    function automatic logic [31:0] div_word(logic [31:0] a, logic [31:0] b);
        if (b == 0) return 32'hFFFF_FFFF;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h8000_0000;
        return $unsigned($signed(a) / $signed(b));
    endfunction

    function automatic logic [31:0] rem_word(logic [31:0] a, logic [31:0] b);
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
        return $unsigned($signed(a) % $signed(b));
    endfunction

    // Executes one word against the shadow state and returns its result.
    function automatic exec_result_t execute_word(logic [31:0] w);
        exec_result_t r;
        logic [6:0]  op, f7, hi;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [31:0] a, b, imm, off, val, npc;
        logic [63:0] prod;
        logic        ok, writes, take;
        op = w[6:0];  rd = w[11:7];  f3 = w[14:12];  f7 = w[31:25];
        a = gpr_model[w[19:15]];  b = gpr_model[w[24:20]];
        imm = {{20{w[31]}}, w[31:20]};
        hi = w[31:25];
        npc = pc_model + 32'd4;
        val = '0;  ok = 1'b1;  writes = 1'b1;
        case (op)
            OP_RTYPE: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD: val = a + b;
                        F3_SLL: val = a << b[4:0];
                        F3_SLT: val = {31'd0, $signed(a) < $signed(b)};
                        F3_XOR: val = a ^ b;
                        F3_SRL: val = a >> b[4:0];
                        F3_OR:  val = a | b;
                        F3_AND: val = a & b;
                        default: ok = 1'b0;
                    endcase
                end else if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_MUL: val = a * b;
                        F3_MULH: begin
                            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                            val = prod[63:32];
                        end
                        F3_DIV: val = div_word(a, b);
                        F3_REM: val = rem_word(a, b);
                        default: ok = 1'b0;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    val = a - b;
                end else if (f7 == F7_ALT && f3 == F3_SRL) begin
                    val = sra_word(a, b[4:0]);
                end else begin
                    ok = 1'b0;
                end
            end
            OP_ITYPE: begin
                case (f3)
                    F3_ADD: val = a + imm;
                    F3_SLL: if (hi == F7_BASE) val = a << w[24:20]; else ok = 1'b0;
                    F3_SLT: val = {31'd0, $signed(a) < $signed(imm)};
                    F3_XOR: val = a ^ imm;
                    F3_SRL: begin
                        if (hi == F7_BASE) val = a >> w[24:20];
                        else if (hi == F7_ALT) val = sra_word(a, w[24:20]);
                        else ok = 1'b0;
                    end
                    F3_OR:  val = a | imm;
                    F3_AND: val = a & imm;
                    default: ok = 1'b0;
                endcase
            end
            OP_BRANCH: begin
                off = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                writes = 1'b0;
                take = 1'b0;
                if (f3 == F3_BEQ) take = (a == b);
                else if (f3 == F3_BNE) take = (a != b);
                else ok = 1'b0;
                if (take) npc = pc_model + off;
            end
            OP_JAL: begin
                off = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                val = pc_model + 32'd4;
                npc = pc_model + off;
            end
            OP_LUI:   val = {w[31:12], 12'd0};
            OP_AUIPC: val = pc_model + {w[31:12], 12'd0};
            default:  ok = 1'b0;
        endcase
        if (!ok) return '{pc_model, 5'd0, 32'd0, 1'b0, 1'b1};
        if (!writes || rd == 0) begin
            rd = '0;  val = '0;  writes = 1'b0;
        end else begin
            gpr_model[rd] = val;
        end
        pc_model = npc;
        r = '{npc, rd, val, writes, 1'b0};
        return r;
    endfunction

    // Mostly supported encodings with random registers, some raw noise.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        logic [2:0]  f3;
        int pick;
        w = $urandom();
        pick = $urandom_range(0, 99);
        f3 = w[14:12];
        if (pick < 35) begin
            w[6:0] = OP_RTYPE;
            case ($urandom_range(0, 3))
                0: w[31:25] = F7_BASE;
                1: w[31:25] = F7_MULDIV;
                2: w[31:25] = F7_ALT;
                default: ;
            endcase
        end else if (pick < 65) begin
            w[6:0] = OP_ITYPE;
            if ((f3 == F3_SLL || f3 == F3_SRL) && $urandom_range(0, 3) != 0)
                w[31:25] = ($urandom_range(0, 1) != 0) ? F7_ALT : F7_BASE;
        end else if (pick < 75) begin
            w[6:0] = OP_BRANCH;
            if ($urandom_range(0, 3) != 0) w[14:12] = 3'($urandom_range(0, 1));
        end else if (pick < 80) w[6:0] = OP_JAL;
        else if (pick < 87) w[6:0] = OP_LUI;
        else if (pick < 93) w[6:0] = OP_AUIPC;
        return w;
    endfunction

    // Valid stays high after acceptance so words can go back to back; idle gaps drop it.
    task automatic send_word(logic [31:0] w, logic has_fixed, exec_result_t fixed);
        exec_result_t predicted;
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_instruction_word <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = execute_word(w);
        if (has_fixed && predicted != fixed) begin
            $error("table row for word %h disagrees with predictor", w);
            error_count++;
        end
        result_queue.push_back(has_fixed ? fixed : predicted);
        words_sent++;
    endtask

    // Result word check and receiver stalls.
    always @(posedge aclk) begin
        exec_result_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end else begin
                    exp_r = result_queue.pop_front();
                    words_checked++;
                    if (m_next_pc !== exp_r.next_pc) begin
                        $error("next_pc exp %h got %h", exp_r.next_pc, m_next_pc);
                        error_count++;
                    end
                    if (m_dest_index !== exp_r.dest_index) begin
                        $error("dest_index exp %0d got %0d", exp_r.dest_index, m_dest_index);
                        error_count++;
                    end
                    if (m_write_value !== exp_r.write_value) begin
                        $error("write_value exp %h got %h", exp_r.write_value, m_write_value);
                        error_count++;
                    end
                    if (m_reg_written !== exp_r.reg_written) begin
                        $error("reg_written exp %b got %b", exp_r.reg_written, m_reg_written);
                        error_count++;
                    end
                    if (m_status !== exp_r.status) begin
                        $error("status exp %b got %b", exp_r.status, m_status);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_gap_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rv32im_integer_execute_core test failed");
            $finish;
        end
    end

    stim_row_t stim_table [$];

    function automatic stim_row_t row(logic [31:0] w);
        return '{w, 1'b0, '0};
    endfunction

    function automatic stim_row_t fixed_row(logic [31:0] w, exec_result_t r);
        return '{w, 1'b1, r};
    endfunction

    initial begin
        int phase;
        // x1 = -1, x2 = 0x80000000, x3 = 0x7FFFF000
        stim_table.push_back(fixed_row(32'h00000000, '{32'd0, 5'd0, 32'd0, 1'b0, 1'b1}));
        stim_table.push_back(fixed_row(32'hFFF00093, '{32'd4, 5'd1, 32'hFFFFFFFF, 1'b1, 1'b0}));
        stim_table.push_back(fixed_row(32'h80000137, '{32'd8, 5'd2, 32'h80000000, 1'b1, 1'b0}));
        stim_table.push_back(fixed_row(32'h7FFFF1B7, '{32'd12, 5'd3, 32'h7FFFF000, 1'b1, 1'b0}));
        stim_table.push_back(fixed_row(32'h00000017, '{32'd16, 5'd0, 32'd0, 1'b0, 1'b0}));
        stim_table.push_back(fixed_row(32'h0000B033, '{32'd16, 5'd0, 32'd0, 1'b0, 1'b1}));
        stim_table.push_back(row(32'h00110233));  // add x4,x2,x1
        stim_table.push_back(row(32'h402082B3));  // sub
        stim_table.push_back(row(32'h00111333));  // sll by low 5 bits of -1
        stim_table.push_back(row(32'h401153B3));  // sra
        stim_table.push_back(row(32'h0020A433));  // slt signed
        stim_table.push_back(row(32'h021104B3));  // mul
        stim_table.push_back(row(32'h02111533));  // mulh
        stim_table.push_back(row(32'h021145B3));  // div overflow
        stim_table.push_back(row(32'h02116633));  // rem overflow
        stim_table.push_back(row(32'h020146B3));  // div by zero
        stim_table.push_back(row(32'h02016733));  // rem by zero
        stim_table.push_back(row(32'h41F15793));  // srai 31
        stim_table.push_back(row(32'h80012813));  // slti min imm
        stim_table.push_back(row(32'h40111893));  // slli bad upper bits
        stim_table.push_back(row(32'h00108463));  // beq taken
        stim_table.push_back(row(32'hFE109EE3));  // bne not taken, backward offset
        stim_table.push_back(row(32'h0020B063));  // branch funct3 3 unsupported
        stim_table.push_back(row(32'h800000EF));  // jal max negative
        stim_table.push_back(row(32'h00000067));  // jalr unsupported

        gpr_model = '{default: '0};
        pc_model = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i])
            send_word(stim_table[i].word, stim_table[i].has_fixed, stim_table[i].fixed);

        for (phase = 0; phase < 3; phase++) begin
            sender_gap_pct   = (phase == 0) ? 6 : (phase == 1) ? 47 : 0;
            receiver_gap_pct = (phase == 0) ? 47 : (phase == 1) ? 6 : 0;
            for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
                if (n == 100) begin
                    s_valid <= 1'b0;
                    wait (result_queue.size() == 0);
                end
                send_word(random_word(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        wait (result_queue.size() == 0);
        repeat (50) @(posedge aclk);
        $display("Sent %0d instruction words (ALU, mul/div, branch, jump, upper-imm, invalid)",
                 words_sent);
        $display("and checked %0d result words under three stall patterns.", words_checked);
        if (error_count == 0 && result_queue.size() == 0)
            $display("rv32im_integer_execute_core test passed");
        else
            $display("rv32im_integer_execute_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
